// ----- rtl/core/cunr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Combination unranker package
// Shared field widths, controller states, command and status structs.
// ----------------------------------------------------------------------------
package cunr_pkg;

	localparam int IDX_W  = 7;
	localparam int RANK_W = 61;
	localparam int EIDX_W = 6;
	localparam int STAT_W = 2;
	localparam int IN_W   = 80;
	localparam int OUT_W  = 8;

	typedef enum logic [STAT_W-1:0] {
		RES_OK     = 2'd0,
		RES_EMPTY  = 2'd1,
		RES_EXCEED = 2'd2
	} res_status_t;

	typedef enum logic [2:0] {
		FSM_FILL,
		FSM_IDLE,
		FSM_CHECK,
		FSM_SPECIAL,
		FSM_SAT,
		FSM_WALK
	} fsm_state_t;

	typedef struct packed {
		logic fill;
		logic load;
		logic rd_first;
		logic sat;
		logic step;
		logic emit_special;
	} cunr_cmd_t;

	typedef struct packed {
		logic fill_done;
		logic special;
		logic out_free;
		logic take_last;
	} cunr_stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/cunr_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Combination unranker controller
// Sequences the table build, the rank check and the element walk.
// ----------------------------------------------------------------------------
module cunr_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_axis_tvalid,
	output logic                 s_axis_tready,
	input  cunr_pkg::cunr_stat_t stat,
	output cunr_pkg::cunr_cmd_t  cmd
);
	import cunr_pkg::*;

	fsm_state_t state_q;
	fsm_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_FILL;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			FSM_FILL: begin
				if (stat.fill_done) state_nx = FSM_IDLE;
			end
			FSM_IDLE: begin
				if (s_axis_tvalid) state_nx = FSM_CHECK;
			end
			FSM_CHECK: begin
				state_nx = stat.special ? FSM_SPECIAL : FSM_SAT;
			end
			FSM_SPECIAL: begin
				if (stat.out_free) state_nx = FSM_IDLE;
			end
			FSM_SAT: begin
				state_nx = FSM_WALK;
			end
			FSM_WALK: begin
				if (stat.out_free && stat.take_last) state_nx = FSM_IDLE;
			end
			default: begin
				state_nx = FSM_FILL;
			end
		endcase
	end

	always_comb begin
		cmd           = '0;
		s_axis_tready = 1'b0;
		case (state_q)
			FSM_FILL: begin
				cmd.fill = 1'b1;
			end
			FSM_IDLE: begin
				s_axis_tready = 1'b1;
				cmd.load      = s_axis_tvalid;
			end
			FSM_CHECK: begin
				cmd.rd_first = !stat.special;
			end
			FSM_SPECIAL: begin
				cmd.emit_special = stat.out_free;
			end
			FSM_SAT: begin
				cmd.sat = 1'b1;
			end
			FSM_WALK: begin
				cmd.step = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/core/cunr_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Combination unranker datapath
// Binomial table memory with its build pass, walk registers and output beat.
// ----------------------------------------------------------------------------
module cunr_datapath #(
	parameter int MAX_SET = 64
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  cunr_pkg::cunr_cmd_t               cmd,
	output cunr_pkg::cunr_stat_t              stat,
	input  wire  [cunr_pkg::IDX_W-1:0]        in_set_size,
	input  wire  [cunr_pkg::IDX_W-1:0]        in_pick_count,
	input  wire  [cunr_pkg::RANK_W-1:0]       in_rank,
	output logic                              m_axis_tvalid,
	input  wire                               m_axis_tready,
	output logic [cunr_pkg::EIDX_W-1:0]       out_element_index,
	output logic                              out_is_last,
	output logic [cunr_pkg::STAT_W-1:0]       out_status
);
	import cunr_pkg::*;

	localparam int ROW_LEN = MAX_SET + 1;
	localparam int DEPTH   = ROW_LEN * ROW_LEN;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam logic [IDX_W-1:0]  MAX_IDX = IDX_W'(MAX_SET);
	localparam logic [ADDR_W-1:0] ROW_A   = ADDR_W'(ROW_LEN);

	function automatic logic [ADDR_W-1:0] tab_addr(input logic [IDX_W-1:0] row,
		input logic [IDX_W-1:0] col);
		tab_addr = ADDR_W'(row) * ROW_A + ADDR_W'(col);
	endfunction

	function automatic logic [IDX_W-1:0] sub_clamp(input logic [IDX_W-1:0] a,
		input logic [IDX_W-1:0] b, input logic [IDX_W-1:0] c);
		logic [IDX_W:0] d;
		d = {1'b0, a} - {1'b0, b} - {1'b0, c};
		sub_clamp = d[IDX_W] ? '0 : d[IDX_W-1:0];
	endfunction

	logic [RANK_W-1:0] tab_mem [DEPTH];
	logic [RANK_W-1:0] rd_a_q;
	logic [RANK_W-1:0] rd_b_q;
	logic [ADDR_W-1:0] ra;
	logic [ADDR_W-1:0] rb;
	logic [ADDR_W-1:0] wa;
	logic [RANK_W-1:0] wd;
	logic              re_a;
	logic              re_b;
	logic              we;

	logic [IDX_W-1:0]  fill_a_q;
	logic [IDX_W-1:0]  fill_b_q;
	logic              fill_issued_q;
	logic              fill_done_q;
	logic              fill_issue;
	logic              fv_s1;
	logic [IDX_W-1:0]  fa_s1;
	logic [IDX_W-1:0]  fb_s1;
	logic [RANK_W-1:0] prev_q;

	logic [IDX_W-1:0]  n_q;
	logic [IDX_W-1:0]  r_q;
	logic [RANK_W-1:0] rank_q;
	logic [RANK_W-1:0] off_q;
	logic [IDX_W-1:0]  j_q;
	logic [IDX_W-1:0]  taken_q;
	logic              took_q;

	logic [RANK_W-1:0] w;
	logic [RANK_W:0]   sum;
	logic              take;
	logic              take_last;
	logic [IDX_W-1:0]  m_next;
	logic [IDX_W-1:0]  k_a;
	logic [IDX_W-1:0]  k_b;
	logic              special;
	logic              out_free;
	logic              out_load;

	assign fill_issue = cmd.fill && !fill_issued_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_a_q      <= '0;
			fill_b_q      <= '0;
			fill_issued_q <= 1'b0;
			fill_done_q   <= 1'b0;
			fv_s1         <= 1'b0;
		end else begin
			fv_s1 <= fill_issue;
			if (fill_issue) begin
				if (fill_b_q == MAX_IDX) begin
					fill_b_q <= '0;
					if (fill_a_q == MAX_IDX) begin
						fill_issued_q <= 1'b1;
					end else begin
						fill_a_q <= fill_a_q + 1'b1;
					end
				end else begin
					fill_b_q <= fill_b_q + 1'b1;
				end
			end
			if (fv_s1 && fa_s1 == MAX_IDX && fb_s1 == MAX_IDX) begin
				fill_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fill_issue) begin
			fa_s1 <= fill_a_q;
			fb_s1 <= fill_b_q;
		end
		if (fv_s1) begin
			prev_q <= rd_a_q;
		end
	end

	always_comb begin
		if (fb_s1 == '0) begin
			wd = RANK_W'(1);
		end else if (fa_s1 == '0 || fb_s1 > fa_s1) begin
			wd = '0;
		end else begin
			wd = prev_q + rd_a_q;
		end
		we = fv_s1;
		wa = tab_addr(fa_s1, fb_s1);
	end

	assign w         = took_q ? rd_b_q : rd_a_q;
	assign sum       = {1'b0, off_q} + {1'b0, w};
	assign take      = sum > {1'b0, rank_q};
	assign take_last = take && (taken_q + 1'b1 == r_q);
	assign m_next    = sub_clamp(n_q, j_q, IDX_W'(2));
	assign k_a       = sub_clamp(r_q, taken_q, IDX_W'(1));
	assign k_b       = sub_clamp(r_q, taken_q, IDX_W'(2));
	assign special   = (r_q == '0) || (r_q > n_q);

	always_comb begin
		re_a = fill_issue || cmd.rd_first || cmd.step;
		re_b = cmd.rd_first || cmd.step;
		if (cmd.fill) begin
			ra = tab_addr(sub_clamp(fill_a_q, '0, IDX_W'(1)), fill_b_q);
		end else if (cmd.rd_first) begin
			ra = tab_addr(n_q - 1'b1, r_q - 1'b1);
		end else begin
			ra = tab_addr(m_next, k_a);
		end
		if (cmd.rd_first) begin
			rb = tab_addr(n_q, r_q);
		end else begin
			rb = tab_addr(m_next, k_b);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			tab_mem[wa] <= wd;
		end
		if (re_a) begin
			rd_a_q <= tab_mem[ra];
		end
		if (re_b) begin
			rd_b_q <= tab_mem[rb];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q    <= (in_set_size > MAX_IDX) ? MAX_IDX : in_set_size;
			r_q    <= in_pick_count;
			rank_q <= in_rank;
		end
		if (cmd.sat) begin
			if (rank_q >= rd_b_q) begin
				rank_q <= rd_b_q - 1'b1;
			end
			off_q   <= '0;
			j_q     <= '0;
			taken_q <= '0;
			took_q  <= 1'b0;
		end
		if (cmd.step) begin
			j_q <= j_q + 1'b1;
			if (take) begin
				taken_q <= taken_q + 1'b1;
				took_q  <= 1'b1;
			end else begin
				off_q  <= sum[RANK_W-1:0];
				took_q <= 1'b0;
			end
		end
	end

	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign out_load = cmd.emit_special || (cmd.step && take);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_load) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_special) begin
			out_element_index <= '0;
			out_is_last       <= 1'b1;
			out_status        <= (r_q == '0) ? RES_EMPTY : RES_EXCEED;
		end else if (cmd.step && take) begin
			out_element_index <= j_q[EIDX_W-1:0];
			out_is_last       <= taken_q + 1'b1 == r_q;
			out_status        <= RES_OK;
		end
	end

	always_comb begin
		stat.fill_done = fill_done_q;
		stat.special   = special;
		stat.out_free  = out_free;
		stat.take_last = take_last;
	end

`ifndef NO_ASSERTIONS
	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("Result beat overwritten before it was taken.");
	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (taken_q < r_q) && (j_q < n_q))
		else $error("Element walk ran past the set or the pick count.");
	a_offset_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> off_q <= rank_q)
		else $error("Running offset exceeds the rank.");
	a_rank_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sat |=> rank_q < rd_b_q)
		else $error("Rank not below the subset count after saturation.");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/combination_unranker_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Combination unranker core
// Emits the element indices of the rank-th r-subset of n in lexicographic order.
// ----------------------------------------------------------------------------
// Channel  Dir  Contents
// s_axis   in   tdata: set_size[6:0], pick_count[13:7], rank[74:14]
// m_axis   out  tdata: element_index[5:0]; tlast: is_last; tuser: status
//
// After reset the binomial table is built with s_axis_tready low.
// An item is loaded, checked, has its rank saturated below the subset count and
// is then walked one element per step; special cases emit one status beat instead.
// The walk reads two table entries each cycle that m_axis does not stall, one per possible outcome.
// A stalled m_axis holds the walk; s_axis_tready is high only between items.
// ----------------------------------------------------------------------------
module combination_unranker_core #(
	parameter int MAX_SET = 64
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_axis_tvalid,
	output logic                           s_axis_tready,
	input  wire  [cunr_pkg::IN_W-1:0]      s_axis_tdata,  // set_size, pick_count, rank
	output logic                           m_axis_tvalid,
	input  wire                            m_axis_tready,
	output logic [cunr_pkg::OUT_W-1:0]     m_axis_tdata,  // element_index, zero pad
	output logic                           m_axis_tlast,
	output logic [cunr_pkg::STAT_W-1:0]    m_axis_tuser   // status
);
	import cunr_pkg::*;

	cunr_cmd_t         cmd;
	cunr_stat_t        stat;
	logic [EIDX_W-1:0] element_index;

	cunr_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.stat          (stat),
		.cmd           (cmd)
	);

	cunr_datapath #(
		.MAX_SET (MAX_SET)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.in_set_size       (s_axis_tdata[IDX_W-1:0]),
		.in_pick_count     (s_axis_tdata[2*IDX_W-1:IDX_W]),
		.in_rank           (s_axis_tdata[2*IDX_W+RANK_W-1:2*IDX_W]),
		.m_axis_tvalid     (m_axis_tvalid),
		.m_axis_tready     (m_axis_tready),
		.out_element_index (element_index),
		.out_is_last       (m_axis_tlast),
		.out_status        (m_axis_tuser)
	);

	assign m_axis_tdata = {{(OUT_W-EIDX_W){1'b0}}, element_index};

endmodule
`default_nettype wire
